>>> hw/rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared sizes for the insertion sorter and its element memory.
// ----------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 32;

endpackage

`default_nettype wire

>>> hw/rtl/insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Insertion sorter for runs of signed 32-bit values, held in one element RAM.
// ----------------------------------------------------------------------------
// Each value taken on the slave stream is inserted into a sorted list kept in
// a 64-entry RAM; the transaction with tlast set closes the set, and the whole
// list is then sent out in ascending order, tlast marking the final element
// and tuser flagging a set from which values beyond capacity were dropped.
// One RAM read and one RAM write per cycle set the timing. The linear
// search (search_mode 0) reads the list from its top and shifts each of the
// k entries larger than the new value up by one before writing the value.
// The binary search (search_mode 1) makes at most ceil(log2(n + 1)) probes
// into a list of n entries, then shifts the k entries above the insertion
// point up in the same way. A value that arrives while the RAM is full is
// dropped. Each result of a set is read from the RAM and then loaded into
// the output register; the read waits while the master side stalls. The
// user must write search_mode over the cfg channel only while the unit is
// idle; the unit itself does not enforce this.
`default_nettype none

module insertion_sorter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: bit 0 is search_mode.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // Slave stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tlast,   // end_of_set
    // Master stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic             m_axis_tlast,   // final_result
    output logic             m_axis_tuser    // [0] overflow
);

    localparam int AW = isort_pkg::ADDR_W;
    localparam int CW = isort_pkg::CNT_W;
    localparam int DW = isort_pkg::DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIN_RD,
        ST_BIN_CMP,
        ST_SCAN,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg;
    logic                 binary_reg, binary_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [CW-1:0]        p_reg, p_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic signed [DW-1:0] value_reg, value_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DW-1:0]        out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [DW-1:0]        ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [DW-1:0]        ram_rd_data;

    logic [CW-1:0]        mid;
    logic [CW:0]          mid_sum;
    logic                 move;
    logic [CW-1:0]        p_dec;

    isort_ram #(
        .WIDTH(DW),
        .DEPTH(isort_pkg::MAX_ELEMENTS)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = CW'(mid_sum >> 1);
    assign move    = binary_reg || ($signed(ram_rd_data) > value_reg);
    assign p_dec   = p_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        binary_next    = binary_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        p_next         = p_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = p_reg[AW-1:0];
        ram_wr_data    = value_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    value_next  = s_axis_tdata;
                    last_next   = s_axis_tlast;
                    binary_next = mode_reg;
                    pos_next    = '0;
                    p_next      = count_reg;
                    if (count_reg == CW'(isort_pkg::MAX_ELEMENTS))
                    begin
                        ovf_next = 1'b1;
                        p_next   = '0;
                        if (s_axis_tlast)
                        begin
                            state_next = ST_OUT_RD;
                        end
                    end
                    else if (mode_reg)
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = ST_BIN_RD;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(count_reg - CW'(1));
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_BIN_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid[AW-1:0];
                    state_next  = ST_BIN_CMP;
                end
                else
                begin
                    pos_next = lo_reg;
                    p_next   = count_reg;
                    if (count_reg == lo_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(count_reg - CW'(1));
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_BIN_CMP:
            begin
                if (value_reg == $signed(ram_rd_data))
                begin
                    lo_next = mid;
                    hi_next = mid;
                end
                else if (value_reg < $signed(ram_rd_data))
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + CW'(1);
                end
                state_next = ST_BIN_RD;
            end

            ST_SCAN:
            begin
                ram_wr_en = 1'b1;
                if (move)
                begin
                    ram_wr_data = ram_rd_data;
                    p_next      = p_dec;
                    if (p_dec == pos_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(p_reg - CW'(2));
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    p_next     = '0;
                    state_next = last_reg ? ST_OUT_RD : ST_IDLE;
                end
            end

            ST_WRITE:
            begin
                ram_wr_en  = 1'b1;
                count_next = count_reg + CW'(1);
                p_next     = '0;
                state_next = last_reg ? ST_OUT_RD : ST_IDLE;
            end

            ST_OUT_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = p_reg[AW-1:0];
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_OUT_LD;
                end
            end

            ST_OUT_LD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = ram_rd_data;
                out_ovf_next   = ovf_reg;
                out_last_next  = (p_reg == count_reg - CW'(1));
                if (p_reg == count_reg - CW'(1))
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    p_next     = p_reg + CW'(1);
                    state_next = ST_OUT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            binary_reg    <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            p_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            pos_reg       <= '0;
            value_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            binary_reg    <= binary_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            p_reg         <= p_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            pos_reg       <= pos_next;
            value_reg     <= value_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/isort_ram.sv
// ----------------------------------------------------------------------------
// isort_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
